### src/gzip_header_parser_defines.svh
// Assertion macros for the gzip header parser RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef GZIP_HEADER_PARSER_DEFINES_SVH
`define GZIP_HEADER_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while in reset.
`define GZHP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define GZHP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define GZHP_ASSERT(label, prop, msg)
`define GZHP_NEVER(label, cond, msg)

`endif

`endif

### src/gzhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gzhp_pkg;

	// Parser phases
	localparam logic [3:0] PH_FIXED   = 4'd0;
	localparam logic [3:0] PH_XLEN_LO = 4'd1;
	localparam logic [3:0] PH_XLEN_HI = 4'd2;
	localparam logic [3:0] PH_EXTRA   = 4'd3;
	localparam logic [3:0] PH_NAME    = 4'd4;
	localparam logic [3:0] PH_COMMENT = 4'd5;
	localparam logic [3:0] PH_HCRC_LO = 4'd6;
	localparam logic [3:0] PH_HCRC_HI = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;

	// FLG bits
	localparam int FLG_HCRC_BIT    = 1;
	localparam int FLG_EXTRA_BIT   = 2;
	localparam int FLG_NAME_BIT    = 3;
	localparam int FLG_COMMENT_BIT = 4;

	// Fixed header constants
	localparam logic [7:0] ID1_BYTE    = 8'h1F;
	localparam logic [7:0] ID2_BYTE    = 8'h8B;
	localparam logic [7:0] CM_DEFLATE  = 8'h08;
	localparam logic [3:0] FIXED_LAST  = 4'd9;
	localparam logic [3:0] IDX_ID1     = 4'd0;
	localparam logic [3:0] IDX_ID2     = 4'd1;
	localparam logic [3:0] IDX_CM      = 4'd2;
	localparam logic [3:0] IDX_FLG     = 4'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MAGIC  = 2'd1;
	localparam logic [1:0] ERR_METHOD = 2'd2;
	localparam logic [1:0] ERR_TRUNC  = 2'd3;

	// One result word
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       header_done;
		logic [1:0] error_code;
	} gzhp_result_t;

	// First optional section at or after phase 'from' that the flags ask for
	function automatic logic [3:0] next_section(input logic [3:0] from, input logic [7:0] flg);
		logic [3:0] ph;
		ph = PH_PAYLOAD;
		if (from <= PH_HCRC_LO && flg[FLG_HCRC_BIT])
			ph = PH_HCRC_LO;
		if (from <= PH_COMMENT && flg[FLG_COMMENT_BIT])
			ph = PH_COMMENT;
		if (from <= PH_NAME && flg[FLG_NAME_BIT])
			ph = PH_NAME;
		if (from <= PH_XLEN_LO && flg[FLG_EXTRA_BIT])
			ph = PH_XLEN_LO;
		return ph;
	endfunction

endpackage

`default_nettype wire

### src/gzhp_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gzip_header_parser_defines.svh"

// Header parse state and the per-word update.
module gzhp_core import gzhp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [7:0]   data_byte,
	input  wire logic         start_of_stream,
	input  wire logic         end_of_input,
	output gzhp_result_t      result
);

	logic [3:0]  phase_q, phase_c, phase_n;
	logic [3:0]  cnt_q, cnt_c, cnt_n;
	logic [7:0]  flags_q, flags_c, flags_n;
	logic [15:0] extra_q, extra_c, extra_n;
	logic [7:0]  lo_q, lo_c, lo_n;
	logic [1:0]  err_q, err_c, err_n;
	logic [1:0]  pend_q, pend_c, pend_n;
	logic        valid;
	logic [15:0] xlen;

	// Start of stream restarts from the reset state
	assign phase_c = start_of_stream ? PH_FIXED : phase_q;
	assign cnt_c   = start_of_stream ? 4'd0 : cnt_q;
	assign flags_c = start_of_stream ? 8'd0 : flags_q;
	assign extra_c = start_of_stream ? 16'd0 : extra_q;
	assign lo_c    = start_of_stream ? 8'd0 : lo_q;
	assign err_c   = start_of_stream ? ERR_NONE : err_q;
	assign pend_c  = start_of_stream ? ERR_NONE : pend_q;
	assign xlen    = {data_byte, lo_c};

	// Next state
	always_comb begin
		phase_n = phase_c;
		cnt_n   = cnt_c;
		flags_n = flags_c;
		extra_n = extra_c;
		lo_n    = lo_c;
		err_n   = err_c;
		pend_n  = pend_c;
		valid   = 1'b0;
		if (err_c == ERR_NONE) begin
			if (end_of_input) begin
				if (phase_c != PH_PAYLOAD)
					err_n = ERR_TRUNC;
			end else begin
				case (phase_c)
					PH_FIXED: begin
						// first fault wins; reported with the result for the tenth byte
						if (pend_c == ERR_NONE) begin
							if (cnt_c == IDX_ID1 && data_byte != ID1_BYTE)
								pend_n = ERR_MAGIC;
							if (cnt_c == IDX_ID2 && data_byte != ID2_BYTE)
								pend_n = ERR_MAGIC;
							if (cnt_c == IDX_CM && data_byte != CM_DEFLATE)
								pend_n = ERR_METHOD;
						end
						if (cnt_c == IDX_FLG)
							flags_n = data_byte;
						if (cnt_c >= FIXED_LAST) begin
							cnt_n = 4'd0;
							if (pend_n != ERR_NONE)
								err_n = pend_n;
							else
								phase_n = next_section(PH_XLEN_LO, flags_c);
						end else begin
							cnt_n = cnt_c + 4'd1;
						end
					end
					PH_XLEN_LO: begin
						lo_n    = data_byte;
						phase_n = PH_XLEN_HI;
					end
					PH_XLEN_HI: begin
						extra_n = xlen;
						phase_n = (xlen != 16'd0) ? PH_EXTRA : next_section(PH_NAME, flags_c);
					end
					PH_EXTRA: begin
						extra_n = extra_c - 16'd1;
						if (extra_c == 16'd1)
							phase_n = next_section(PH_NAME, flags_c);
					end
					PH_NAME: begin
						if (data_byte == 8'd0)
							phase_n = next_section(PH_COMMENT, flags_c);
					end
					PH_COMMENT: begin
						if (data_byte == 8'd0)
							phase_n = next_section(PH_HCRC_LO, flags_c);
					end
					PH_HCRC_LO: phase_n = PH_HCRC_HI;
					PH_HCRC_HI: phase_n = PH_PAYLOAD;
					PH_PAYLOAD: valid = 1'b1;
					default:    phase_n = PH_FIXED;
				endcase
			end
		end
	end

	// Result for this word
	always_comb begin
		result.payload_byte  = valid ? data_byte : 8'd0;
		result.payload_valid = valid;
		result.header_done   = (phase_n == PH_PAYLOAD) && (err_n == ERR_NONE);
		result.error_code    = err_n;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIXED;
			cnt_q   <= 4'd0;
			flags_q <= 8'd0;
			extra_q <= 16'd0;
			lo_q    <= 8'd0;
			err_q   <= ERR_NONE;
			pend_q  <= ERR_NONE;
		end else if (en) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			flags_q <= flags_n;
			extra_q <= extra_n;
			lo_q    <= lo_n;
			err_q   <= err_n;
			pend_q  <= pend_n;
		end
	end

	`GZHP_NEVER(a_cnt_range, cnt_q > FIXED_LAST, "fixed byte count past last header byte")
	`GZHP_NEVER(a_payload_no_err, en && result.payload_valid && result.error_code != ERR_NONE, "payload with error")
	`GZHP_ASSERT(a_payload_done, en && result.payload_valid |-> result.header_done, "payload before header done")
	`GZHP_ASSERT(a_err_sticky, en && err_q != ERR_NONE && !start_of_stream |=> err_q == $past(err_q), "error latch changed without restart")

endmodule

`default_nettype wire

### src/gzip_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// gzip member header parser. Takes one stream byte per cycle unless stalled and returns
// one result word per byte: payload bytes once the header (fixed part, extra field, name,
// comment, header CRC as flagged) is consumed, plus header_done and a latched
// error_code (bad magic, bad method, truncated header) that clears on
// start_of_stream. Throughput is one word per cycle unless stalled; each byte passes
// the input register, then the parse state update, then the result register.
// in_stall follows out_stall when both registers are full.
module gzip_header_parser import gzhp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_of_stream,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            payload_valid,
	output logic            header_done,
	output logic [1:0]      error_code
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         sos_s1;
	logic         eoi_s1;
	logic         out_valid_q;
	gzhp_result_t result_q;
	gzhp_result_t result;
	logic         advance;

	// Result register free or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			sos_s1  <= start_of_stream;
			eoi_s1  <= end_of_input;
		end
	end

	gzhp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (valid_s1 && advance),
		.data_byte       (data_s1),
		.start_of_stream (sos_s1),
		.end_of_input    (eoi_s1),
		.result          (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_q <= result;
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = result_q.payload_byte;
	assign payload_valid = result_q.payload_valid;
	assign header_done   = result_q.header_done;
	assign error_code    = result_q.error_code;

endmodule

`default_nettype wire
